// ===== hw/rtl/fcvr_pkg.sv =====
// Shared types and constants for the face corner vertex remap block.
`default_nettype none

package fcvr_pkg;

  // Field widths
  localparam int REG_W     = 13;  // config registers and corner indices
  localparam int IDX_W     = 14;  // final vertex index
  localparam int SRC_W     = 12;  // 0-based source attribute indices
  localparam int CODE_W    = 2;   // action and status codes
  localparam int CFG_IDX_W = 2;   // config register index

  // Config register indices
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXCOORD_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_COUNT   = 2'd2;

  // Action codes
  localparam logic [CODE_W-1:0] ACT_REUSE = 2'd0;
  localparam logic [CODE_W-1:0] ACT_FIRST = 2'd1;
  localparam logic [CODE_W-1:0] ACT_DUP   = 2'd2;

  // Status codes
  localparam logic [CODE_W-1:0] ST_OK    = 2'd0;
  localparam logic [CODE_W-1:0] ST_RANGE = 2'd1;
  localparam logic [CODE_W-1:0] ST_FULL  = 2'd2;
  localparam logic [CODE_W-1:0] ST_SPACE = 2'd3;

  // One input corner
  typedef struct packed {
    logic [REG_W-1:0] corner_position;
    logic [REG_W-1:0] corner_texcoord;
    logic [REG_W-1:0] corner_normal;
  } corner_t;

  // One recorded (texture, normal) variant of a position
  typedef struct packed {
    logic [IDX_W-1:0] vidx;
    logic [REG_W-1:0] tex;
    logic [REG_W-1:0] nrm;
  } variant_t;

  // One result item
  typedef struct packed {
    logic [IDX_W-1:0]  final_index;
    logic [CODE_W-1:0] action;
    logic [SRC_W-1:0]  source_position;
    logic [SRC_W-1:0]  source_texcoord;
    logic [SRC_W-1:0]  source_normal;
    logic [CODE_W-1:0] status;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;  // write one zero into the count memory
    logic accept;    // capture corner, launch memory reads
    logic commit;    // evaluate, update tables, load output register
  } fcvr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last entry
    logic out_block;   // output register holds an item not yet taken
  } fcvr_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcvr_if.sv =====
// Channel interfaces: corner input, result output and config write.
`default_nettype none

interface fcvr_in_if import fcvr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] corner_position;
  logic [REG_W-1:0] corner_texcoord;
  logic [REG_W-1:0] corner_normal;

  modport source (output valid, corner_position, corner_texcoord, corner_normal,
                  input ready);
  modport sink (input valid, corner_position, corner_texcoord, corner_normal,
                output ready);
endinterface

interface fcvr_out_if import fcvr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  final_index;
  logic [CODE_W-1:0] action;
  logic [SRC_W-1:0]  source_position;
  logic [SRC_W-1:0]  source_texcoord;
  logic [SRC_W-1:0]  source_normal;
  logic [CODE_W-1:0] status;

  modport source (output valid, final_index, action, source_position, source_texcoord,
                  source_normal, status, input ready);
  modport sink (input valid, final_index, action, source_position, source_texcoord,
                source_normal, status, output ready);
endinterface

interface fcvr_cfg_if import fcvr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fcvr_ctrl.sv =====
// Controller state machine: clearing pass, corner accept, evaluate/commit.
`default_nettype none

module fcvr_ctrl import fcvr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fcvr_stat_t stat,
  output fcvr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Commands
  assign in_ready     = (state_r == S_IDLE);
  assign cmd.clear_wr = (state_r == S_CLEAR);
  assign cmd.accept   = in_ready && in_valid;
  assign cmd.commit   = (state_r == S_EVAL) && !stat.out_block;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcvr_datapath.sv =====
// Datapath: config registers, count and variant memories, lookup and output register.
`default_nettype none

module fcvr_datapath import fcvr_pkg::*; #(
  parameter int MAX_POSITIONS       = 4096,
  parameter int MAX_VARIANTS        = 4,
  parameter int MAX_OUTPUT_VERTICES = 16384,
  parameter int MAX_ATTRIBUTES      = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcvr_cmd_t            cmd,
  output fcvr_stat_t           stat,
  input  corner_t              corner_in,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output result_t              result
);

  localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int CW = $clog2(MAX_VARIANTS + 1);
  localparam logic [31:0] MAX_POS_U  = 32'(MAX_POSITIONS);
  localparam logic [31:0] MAX_ATTR_U = 32'(MAX_ATTRIBUTES);
  localparam logic [31:0] MAX_OV_U   = 32'(MAX_OUTPUT_VERTICES);
  localparam logic [CW-1:0] MAX_VAR_C = CW'(MAX_VARIANTS);
  localparam logic [PW-1:0] CLR_LAST  = PW'(MAX_POSITIONS - 1);

  // Config registers
  logic [REG_W-1:0] pos_count_r, tex_count_r, nrm_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_count_r <= '0;
      tex_count_r <= '0;
      nrm_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POSITION_COUNT: pos_count_r <= cfg_data;
        CFG_TEXCOORD_COUNT: tex_count_r <= cfg_data;
        CFG_NORMAL_COUNT:   nrm_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured corner
  logic [REG_W-1:0] cp_r, ct_r, cn_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cp_r <= corner_in.corner_position;
      ct_r <= corner_in.corner_texcoord;
      cn_r <= corner_in.corner_normal;
    end
  end

  // 0-based indices and memory addresses
  logic [REG_W-1:0] p, t, n;
  logic [PW-1:0]    rd_addr, p_addr;

  assign rd_addr = PW'(corner_in.corner_position - 13'd1);
  assign p       = cp_r - 13'd1;
  assign t       = ct_r - 13'd1;
  assign n       = cn_r - 13'd1;
  assign p_addr  = PW'(p);

  // Clearing pass counter
  logic [PW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  assign stat.clear_last = (clr_r == CLR_LAST);

  // Evaluation results used by the memory writes
  logic             is_first, is_dup;
  logic [CW-1:0]    cnt_new;
  logic [IDX_W-1:0] vidx_new;

  // Per-position variant count (zero means position not yet seen)
  logic [CW-1:0] cnt_mem [MAX_POSITIONS];
  logic [CW-1:0] cnt_rd_r;
  logic          cnt_we;
  logic [PW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  assign cnt_we    = cmd.clear_wr || (cmd.commit && (is_first || is_dup));
  assign cnt_waddr = cmd.clear_wr ? clr_r : p_addr;
  assign cnt_wdata = cmd.clear_wr ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd.accept) cnt_rd_r <= cnt_mem[rd_addr];
  end

  // Variant slot banks, one per slot, all read at the same position
  variant_t                 slot_rd [MAX_VARIANTS];
  logic [MAX_VARIANTS-1:0]  match;
  variant_t                 slot_wdata;

  assign slot_wdata = '{vidx: vidx_new, tex: t, nrm: n};

  for (genvar i = 0; i < MAX_VARIANTS; i++) begin : g_slot
    variant_t bank_mem [MAX_POSITIONS];
    variant_t bank_rd_r;
    logic     bank_we;

    assign bank_we = cmd.commit &&
                     ((is_first && (i == 0)) || (is_dup && (cnt_rd_r == CW'(i))));

    always_ff @(posedge clk) begin
      if (bank_we) bank_mem[p_addr] <= slot_wdata;
      if (cmd.accept) bank_rd_r <= bank_mem[rd_addr];
    end

    assign slot_rd[i] = bank_rd_r;
    assign match[i]   = (cnt_rd_r > CW'(i)) && (bank_rd_r.tex == t) && (bank_rd_r.nrm == n);
  end

  // Duplicate counter
  logic [IDX_W-1:0] dup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_r <= '0;
    end else if (cmd.commit && is_dup) begin
      dup_r <= dup_r + 1'b1;
    end
  end

  // Lookup and decision
  logic             in_ok, seen, hit, full, space;
  logic [IDX_W-1:0] hit_vidx;
  logic [IDX_W:0]   sum;
  result_t          res_nxt;

  assign sum = {2'b00, pos_count_r} + {1'b0, dup_r};

  always_comb begin
    in_ok = (cp_r != '0) && (cp_r <= pos_count_r) && (32'(cp_r) <= MAX_POS_U) &&
            (ct_r != '0) && (ct_r <= tex_count_r) && (32'(ct_r) <= MAX_ATTR_U) &&
            (cn_r != '0) && (cn_r <= nrm_count_r) && (32'(cn_r) <= MAX_ATTR_U);
    seen  = (cnt_rd_r != '0);
    full  = (cnt_rd_r >= MAX_VAR_C);
    space = (32'(sum) >= MAX_OV_U);

    // lowest matching slot wins
    hit      = 1'b0;
    hit_vidx = '0;
    for (int i = MAX_VARIANTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit      = 1'b1;
        hit_vidx = slot_rd[i].vidx;
      end
    end

    is_first = 1'b0;
    is_dup   = 1'b0;
    cnt_new  = cnt_rd_r + 1'b1;
    vidx_new = sum[IDX_W-1:0];
    res_nxt  = '0;

    if (!in_ok) begin
      res_nxt.status = ST_RANGE;
    end else if (!seen) begin
      is_first    = 1'b1;
      cnt_new     = CW'(1);
      vidx_new    = IDX_W'(p);
      res_nxt.final_index = IDX_W'(p);
      res_nxt.action      = ACT_FIRST;
    end else if (hit) begin
      res_nxt.final_index = hit_vidx;
      res_nxt.action      = ACT_REUSE;
    end else if (full) begin
      res_nxt.status = ST_FULL;
    end else if (space) begin
      res_nxt.status = ST_SPACE;
    end else begin
      is_dup = 1'b1;
      res_nxt.final_index = sum[IDX_W-1:0];
      res_nxt.action      = ACT_DUP;
    end

    // successful corners report their 0-based sources
    if (res_nxt.status == ST_OK) begin
      res_nxt.source_position = p[SRC_W-1:0];
      res_nxt.source_texcoord = t[SRC_W-1:0];
      res_nxt.source_normal   = n[SRC_W-1:0];
    end
  end

  // Output register
  logic    out_valid_r, out_valid_nxt;
  result_t result_r;

  assign stat.out_block = out_valid_r && !out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) result_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

// ===== hw/rtl/face_corner_vertex_remap.sv =====
// Top level of the face corner vertex remap block.
//
//  channel  dir  handshake      payload
//  cfg_ch   in   valid/ready    index, data (ready always high)
//  in_ch    in   valid/ready    corner_position, corner_texcoord, corner_normal
//  out_ch   out  valid/ready    final_index, action, source_*, status
//
// Each item first reads the count and variant slot memories at the corner's
// position, then is matched, decided and written back into the tables.
// After reset a clearing pass walks the count memory before the first corner
// is taken; config writes are taken throughout.
// A result not yet taken stalls the next item's write-back until it leaves.
`default_nettype none

module face_corner_vertex_remap import fcvr_pkg::*; #(
  parameter int MAX_POSITIONS       = 4096,
  parameter int MAX_VARIANTS        = 4,
  parameter int MAX_OUTPUT_VERTICES = 16384,
  parameter int MAX_ATTRIBUTES      = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  fcvr_cfg_if.sink          cfg_ch,
  fcvr_in_if.sink           in_ch,
  fcvr_out_if.source        out_ch
);

  fcvr_cmd_t  cmd;
  fcvr_stat_t stat;
  corner_t    corner;
  result_t    result;
  logic       out_valid;

  // Config port never stalls
  assign cfg_ch.ready = 1'b1;

  assign corner.corner_position = in_ch.corner_position;
  assign corner.corner_texcoord = in_ch.corner_texcoord;
  assign corner.corner_normal   = in_ch.corner_normal;

  // Controller
  fcvr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  fcvr_datapath #(
    .MAX_POSITIONS       (MAX_POSITIONS),
    .MAX_VARIANTS        (MAX_VARIANTS),
    .MAX_OUTPUT_VERTICES (MAX_OUTPUT_VERTICES),
    .MAX_ATTRIBUTES      (MAX_ATTRIBUTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .corner_in (corner),
    .cfg_we    (cfg_ch.valid && cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .result    (result)
  );

  // Result channel
  assign out_ch.valid           = out_valid;
  assign out_ch.final_index     = result.final_index;
  assign out_ch.action          = result.action;
  assign out_ch.source_position = result.source_position;
  assign out_ch.source_texcoord = result.source_texcoord;
  assign out_ch.source_normal   = result.source_normal;
  assign out_ch.status          = result.status;

`ifndef NO_ASSERTIONS
  // A commit never overwrites a result that is still waiting
  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_ch.valid && !out_ch.ready))
    else $error("commit while output register still full");

  // One item at a time: accept and commit never coincide
  a_accept_commit_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.commit))
    else $error("accept and commit in the same cycle");

  // After an accept the input side closes until the item is committed
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_ch.ready)
    else $error("input ready right after accept");

  // An error result carries zero index and action
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |->
      ((out_ch.final_index == '0) && (out_ch.action == ACT_REUSE)))
    else $error("error result with nonzero fields");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_face_corner_vertex_remap.sv =====
// Self-checking testbench for the face corner vertex remap block.
module tb_face_corner_vertex_remap import fcvr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POSITION_SLOTS  = 4096;
  localparam int VARIANT_SLOTS   = 4;
  localparam int VERTEX_SPACE    = 16384;
  localparam int ATTRIBUTE_SLOTS = 4096;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AFTER      = 400;
  localparam int PHASE_ITEMS     = 190;

  // Tracks position claims and recorded variants, and holds the remaps still owed
  class remap_predictor;
    int unsigned   pos_count;
    int unsigned   tex_count;
    int unsigned   nrm_count;
    bit            seen[POSITION_SLOTS];
    int unsigned   held[POSITION_SLOTS];
    variant_t      slots[POSITION_SLOTS*VARIANT_SLOTS];
    logic [IDX_W-1:0] dup_count;
    result_t       expected_remaps[$];
    int            mismatches;

    function new();
      pos_count = 0;
      tex_count = 0;
      nrm_count = 0;
      dup_count = '0;
      mismatches = 0;
      foreach (seen[i]) begin
        seen[i] = 1'b0;
        held[i] = 0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_POSITION_COUNT: pos_count = 32'(val);
        CFG_TEXCOORD_COUNT: tex_count = 32'(val);
        CFG_NORMAL_COUNT:   nrm_count = 32'(val);
        default: ;
      endcase
    endfunction

    function bit in_span(int unsigned v, int unsigned count, int unsigned cap);
      return v >= 1 && v <= count && v <= cap;
    endfunction

    // Work out the remap for one accepted corner and update the tables
    function void note_corner(corner_t c);
      result_t     r;
      int unsigned p, t, n, base, cnt, fin;
      bit          hit;
      r = '0;
      if (!in_span(32'(c.corner_position), pos_count, POSITION_SLOTS) ||
          !in_span(32'(c.corner_texcoord), tex_count, ATTRIBUTE_SLOTS) ||
          !in_span(32'(c.corner_normal), nrm_count, ATTRIBUTE_SLOTS)) begin
        r.status = ST_RANGE;
      end else begin
        p = 32'(c.corner_position) - 1;
        t = 32'(c.corner_texcoord) - 1;
        n = 32'(c.corner_normal) - 1;
        base = p * VARIANT_SLOTS;
        r.source_position = SRC_W'(p);
        r.source_texcoord = SRC_W'(t);
        r.source_normal   = SRC_W'(n);
        r.status          = ST_OK;
        if (!seen[p]) begin
          // first corner on this position claims it
          seen[p] = 1'b1;
          slots[base].vidx = IDX_W'(p);
          slots[base].tex  = REG_W'(t);
          slots[base].nrm  = REG_W'(n);
          held[p] = 1;
          r.final_index = IDX_W'(p);
          r.action      = ACT_FIRST;
        end else begin
          cnt = (held[p] > VARIANT_SLOTS) ? VARIANT_SLOTS : held[p];
          hit = 1'b0;
          for (int i = 0; i < cnt; i++) begin
            if (!hit && slots[base+i].tex == REG_W'(t) && slots[base+i].nrm == REG_W'(n)) begin
              hit = 1'b1;
              r.final_index = slots[base+i].vidx;
              r.action      = ACT_REUSE;
            end
          end
          if (!hit) begin
            fin = pos_count + 32'(dup_count);
            if (cnt >= VARIANT_SLOTS) begin
              r = '0;
              r.status = ST_FULL;
            end else if (fin >= VERTEX_SPACE) begin
              r = '0;
              r.status = ST_SPACE;
            end else begin
              // new pair: append a duplicate vertex
              dup_count = dup_count + 1'b1;
              slots[base+cnt].vidx = IDX_W'(fin);
              slots[base+cnt].tex  = REG_W'(t);
              slots[base+cnt].nrm  = REG_W'(n);
              held[p] = cnt + 1;
              r.final_index = IDX_W'(fin);
              r.action      = ACT_DUP;
            end
          end
        end
      end
      expected_remaps.insert(expected_remaps.size(), r);
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Compare one taken result with the oldest owed remap
    function void check_remap(result_t got);
      result_t want;
      if (expected_remaps.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = expected_remaps.pop_front();
      if (got.final_index !== want.final_index)
        report("final_index", 16'(want.final_index), 16'(got.final_index));
      if (got.action !== want.action)
        report("action", 16'(want.action), 16'(got.action));
      if (got.source_position !== want.source_position)
        report("source_position", 16'(want.source_position), 16'(got.source_position));
      if (got.source_texcoord !== want.source_texcoord)
        report("source_texcoord", 16'(want.source_texcoord), 16'(got.source_texcoord));
      if (got.source_normal !== want.source_normal)
        report("source_normal", 16'(want.source_normal), 16'(got.source_normal));
      if (got.status !== want.status)
        report("status", 16'(want.status), 16'(got.status));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fcvr_cfg_if cfg_ch ();
  fcvr_in_if  in_ch ();
  fcvr_out_if out_ch ();

  face_corner_vertex_remap dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  remap_predictor board = new();
  int             burst_left = 0;
  bit             burst_quiet = 1'b0;
  int             remaps_taken = 0;
  int unsigned    cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_face_corner_vertex_remap: done, errors");
    $finish;
  end

  // Result side: check taken items, stall on its own pattern, one long hold-off
  initial begin
    result_t got;
    int      mode;
    int      mode_left;
    int      hold_left;
    bit      hold_done;
    int      tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (out_ch.valid && out_ch.ready) begin
        got.final_index     = out_ch.final_index;
        got.action          = out_ch.action;
        got.source_position = out_ch.source_position;
        got.source_texcoord = out_ch.source_texcoord;
        got.source_normal   = out_ch.source_normal;
        got.status          = out_ch.status;
        board.check_remap(got);
        remaps_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && remaps_taken >= HOLD_AFTER && in_ch.valid) begin
        // block backs up while corners keep coming
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(3, 0);
          mode_left = $urandom_range(80, 8);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1, 0));
          2: out_ch.ready <= ($urandom_range(3, 0) == 0);
          default: out_ch.ready <= (tick % 4 != 3);
        endcase
      end
    end
  end

  // Offer one corner, opening a new burst with a random gap when the last one ran out
  task automatic offer_corner(input corner_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      burst_quiet = ($urandom_range(9, 0) < 3);
      gap = burst_quiet ? 0 : $urandom_range(6, 0);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid           <= 1'b1;
    in_ch.corner_position <= c.corner_position;
    in_ch.corner_texcoord <= c.corner_texcoord;
    in_ch.corner_normal   <= c.corner_normal;
    do @(posedge clk); while (!in_ch.ready);
    board.note_corner(c);
  endtask

  // Drop valid and wait until every owed remap has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.expected_remaps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[REG_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_reg(idx, val[REG_W-1:0]);
  endtask

  task automatic set_counts(input int unsigned pc, input int unsigned tc, input int unsigned nc);
    write_reg(CFG_POSITION_COUNT, pc);
    write_reg(CFG_TEXCOORD_COUNT, tc);
    write_reg(CFG_NORMAL_COUNT, nc);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic corner_t corner_of(int unsigned p, int unsigned t, int unsigned n);
    corner_t c;
    c.corner_position = p[REG_W-1:0];
    c.corner_texcoord = t[REG_W-1:0];
    c.corner_normal   = n[REG_W-1:0];
    return c;
  endfunction

  function automatic int unsigned pick_in(int unsigned count);
    return (count == 0) ? 0 : $urandom_range(count, 1);
  endfunction

  // Lowest, highest loaded and largest legal index
  function automatic int unsigned pick_edge(int unsigned count);
    case ($urandom_range(2, 0))
      0: return 1;
      1: return count;
      default: return POSITION_SLOTS;
    endcase
  endfunction

  function automatic int unsigned pick_bad(int unsigned count);
    case ($urandom_range(2, 0))
      0: return 0;
      1: return (count < POSITION_SLOTS) ? count + 1 : 0;
      default: return (count < POSITION_SLOTS) ? $urandom_range(POSITION_SLOTS, count + 1) : 0;
    endcase
  endfunction

  // Mostly corners on a few hot positions with few pairs, so reuse, duplicates
  // and full variant lists come up; the rest spread, edge and broken corners
  function automatic corner_t pick_corner(int unsigned hot_base);
    int unsigned pc, tc, nc, p, t, n, top;
    int          sel;
    pc = board.pos_count;
    tc = board.tex_count;
    nc = board.nrm_count;
    sel = $urandom_range(99, 0);
    if (sel < 60) begin
      top = (hot_base + 15 < pc) ? hot_base + 15 : pc;
      p = (pc == 0) ? 0 : $urandom_range(top, hot_base);
      t = pick_in((tc < 3) ? tc : 3);
      n = pick_in((nc < 3) ? nc : 3);
    end else if (sel < 80) begin
      p = pick_in(pc);
      t = pick_in(tc);
      n = pick_in(nc);
    end else if (sel < 90) begin
      p = pick_edge(pc);
      t = pick_edge(tc);
      n = pick_edge(nc);
    end else begin
      p = pick_in(pc);
      t = pick_in(tc);
      n = pick_in(nc);
      case ($urandom_range(2, 0))
        0: p = pick_bad(pc);
        1: t = pick_bad(tc);
        default: n = pick_bad(nc);
      endcase
    end
    return corner_of(p, t, n);
  endfunction

  task automatic run_phase(input int unsigned pc, input int unsigned tc, input int unsigned nc);
    int unsigned hot_base;
    hot_base = 0;
    wait_drained();
    set_counts(pc, tc, nc);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 50 == 0)
        hot_base = pick_in(board.pos_count);
      offer_corner(pick_corner(hot_base));
    end
  endtask

  // Stimulus
  initial begin
    rst_n                 <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_POSITION_COUNT;
    cfg_ch.data           <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.corner_position <= '0;
    in_ch.corner_texcoord <= '0;
    in_ch.corner_normal   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // counts still zero after reset: everything is out of range
    offer_corner(corner_of(1, 1, 1));
    offer_corner(corner_of(0, 0, 0));
    offer_corner(corner_of(4096, 4096, 4096));
    wait_drained();
    set_counts(4096, 4096, 4096);

    // claim, reuse, duplicates up to a full variant list
    offer_corner(corner_of(4096, 4096, 4096));
    offer_corner(corner_of(4096, 4096, 4096));
    offer_corner(corner_of(4096, 1, 1));
    offer_corner(corner_of(4096, 1, 4096));
    offer_corner(corner_of(4096, 4096, 1));
    offer_corner(corner_of(4096, 2, 2));
    offer_corner(corner_of(4096, 1, 1));
    offer_corner(corner_of(4096, 4096, 1));
    offer_corner(corner_of(1, 1, 1));
    offer_corner(corner_of(1, 4096, 4096));
    offer_corner(corner_of(1, 1, 1));
    // zero index in each field
    offer_corner(corner_of(0, 1, 1));
    offer_corner(corner_of(1, 0, 1));
    offer_corner(corner_of(1, 1, 0));
    // alternating bit patterns
    offer_corner(corner_of(2731, 2730, 1365));
    offer_corner(corner_of(1366, 1365, 2730));
    offer_corner(corner_of(2731, 1365, 2730));

    // one past the count is out of range; duplicates numbered after the new count
    wait_drained();
    set_counts(100, 50, 50);
    offer_corner(corner_of(101, 1, 1));
    offer_corner(corner_of(1, 51, 1));
    offer_corner(corner_of(1, 1, 51));
    offer_corner(corner_of(100, 50, 50));
    offer_corner(corner_of(1, 2, 2));

    run_phase(4096, 4096, 4096);
    run_phase(16, 4, 4);
    run_phase(1, 1, 1);
    run_phase(0, 0, 0);
    run_phase(4096, 2, 3);
    run_phase(300, 4096, 4096);
    run_phase($urandom_range(4096, 0), $urandom_range(4096, 0), $urandom_range(4096, 0));
    run_phase(64, 8, 8);
    run_phase(4096, 4096, 4096);

    wait_drained();
    if (board.mismatches == 0)
      $display("tb_face_corner_vertex_remap: done, clean");
    else
      $display("tb_face_corner_vertex_remap: done, errors");
    $finish;
  end

endmodule
